// ===== src/tkst_pkg.sv =====
// Package for the top-K extreme and spread tracker.
// Holds the reading type, range bounds, default sizes, the sequencer state
// type and the control struct shared by the sequencer and the list unit.
`default_nettype none
package tkst_pkg;

	// Reading width and range.
	localparam int TEMP_W    = 9;
	localparam int TEMP_LOW  = -100;
	localparam int TEMP_HIGH = 171;

	// Widths of the report fields that are fixed.
	localparam int SPREAD_W  = 9;
	localparam int ROW_OUT_W = 6;

	// Default sizes handed to the top level parameters.
	localparam int LANES_DEF    = 8;
	localparam int TOP_K_DEF    = 5;
	localparam int MAX_ROWS_DEF = 64;

	typedef logic signed [TEMP_W-1:0] temp_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_SPREAD,
		ST_REPORT
	} tkst_state_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic ins_en;    // insert the selected reading into the lists
		logic first;     // first reading of the row: restart row min and max
		logic spread_en; // compare the row spread with the kept one
		logic out_load;  // load the report into the output register
		logic clear;     // return the report period state to its reset values
	} ctrl_t;

	// Limit a raw reading to the legal range.
	function automatic temp_t clamp_temp(input temp_t raw);
		temp_t res;
		if (raw < temp_t'(TEMP_LOW)) begin
			res = temp_t'(TEMP_LOW);
		end else if (raw > temp_t'(TEMP_HIGH)) begin
			res = temp_t'(TEMP_HIGH);
		end else begin
			res = raw;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== src/top_k_extreme_and_spread_tracker.sv =====
// Top level of the top-K extreme and spread tracker: row register, spread
// and row bookkeeping, report register and stream ports.
// Depends on tkst_pkg, tkst_ctrl and tkst_lists.
//
//  Port group  Dir  Content
//  s_axis      in   one row of LANES readings, tlast = end of report
//  m_axis      out  report: top and bottom lists, largest spread, its row
//
// A row is accepted, its readings then pass one after another through the
// shared insertion unit, and the spread update follows; an end-of-report row
// then loads the report. Ready is low while a row is at work. A report
// not yet taken holds in the output register while further rows are taken;
// only the next report waits for it. Reset sets the lists to the range bounds
// and clears spread, row index and the output valid flag.
`default_nettype none
module top_k_extreme_and_spread_tracker
	import tkst_pkg::*;
#(
	parameter int LANES    = LANES_DEF,
	parameter int TOP_K    = TOP_K_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        s_axis_tvalid,
	output logic                                             s_axis_tready,
	// temp_0 .. temp_LANES-1, 9 bits each, from the lowest bit up
	input  wire logic [((LANES*TEMP_W+7)/8)*8-1:0]           s_axis_tdata,
	// end_of_report
	input  wire logic                                        s_axis_tlast,
	output logic                                             m_axis_tvalid,
	input  wire logic                                        m_axis_tready,
	// high_rank_1 .. high_rank_TOP_K, low_rank_1 .. low_rank_TOP_K,
	// largest_spread, spread_row, from the lowest bit up
	output logic [((2*TOP_K*TEMP_W+SPREAD_W+ROW_OUT_W+7)/8)*8-1:0] m_axis_tdata
);

	localparam int LANE_W    = $clog2(LANES);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int ROW_EXT_W = (ROW_W > ROW_OUT_W) ? ROW_W : ROW_OUT_W;
	localparam int OUT_W     = ((2*TOP_K*TEMP_W + SPREAD_W + ROW_OUT_W + 7) / 8) * 8;
	localparam int SPREAD_LO = 2 * TOP_K * TEMP_W;
	localparam int ROW_LO    = SPREAD_LO + SPREAD_W;

	ctrl_t ctrl;
	logic in_fire, out_free;
	logic [LANE_W-1:0] lane;
	temp_t row_q [LANES];
	logic eor_q;
	temp_t lane_value;
	temp_t high_list [TOP_K];
	temp_t low_list [TOP_K];
	temp_t row_min, row_max;
	logic signed [TEMP_W:0] diff;
	logic [SPREAD_W-1:0] spread;
	logic [SPREAD_W-1:0] best_spread_q;
	logic [ROW_W-1:0] best_row_q, row_count_q;
	logic [ROW_EXT_W-1:0] row_ext;
	logic [OUT_W-1:0] out_word, out_data_q;
	logic out_valid_q;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	tkst_ctrl #(
		.LANES(LANES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.eor     (eor_q),
		.out_free(out_free),
		.in_ready(s_axis_tready),
		.lane    (lane),
		.ctrl    (ctrl)
	);

	// Row register, loaded on an accepted transfer.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < LANES; i++) begin
				row_q[i] <= temp_t'(s_axis_tdata[i*TEMP_W +: TEMP_W]);
			end
			eor_q <= s_axis_tlast;
		end
	end

	assign lane_value = clamp_temp(row_q[lane]);

	tkst_lists #(
		.TOP_K(TOP_K)
	) u_lists (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.value    (lane_value),
		.high_list(high_list),
		.low_list (low_list),
		.row_min  (row_min),
		.row_max  (row_max)
	);

	// Spread of the finished row; it is never negative and fits in 9 bits.
	assign diff   = {row_max[TEMP_W-1], row_max} - {row_min[TEMP_W-1], row_min};
	assign spread = diff[SPREAD_W-1:0];

	// Largest spread, its row, and the row index of the report period.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_spread_q <= '0;
			best_row_q    <= '0;
			row_count_q   <= '0;
		end else if (ctrl.clear) begin
			best_spread_q <= '0;
			best_row_q    <= '0;
			row_count_q   <= '0;
		end else if (ctrl.spread_en) begin
			if (spread > best_spread_q) begin
				best_spread_q <= spread;
				best_row_q    <= row_count_q;
			end
			if (row_count_q == ROW_W'(MAX_ROWS - 1)) begin
				row_count_q <= '0;
			end else begin
				row_count_q <= row_count_q + 1'b1;
			end
		end
	end

	// Report word, packed from the lowest bit up.
	assign row_ext = ROW_EXT_W'(best_row_q);
	always_comb begin
		out_word = '0;
		for (int i = 0; i < TOP_K; i++) begin
			out_word[i*TEMP_W +: TEMP_W]         = high_list[i];
			out_word[(TOP_K+i)*TEMP_W +: TEMP_W] = low_list[i];
		end
		out_word[SPREAD_LO +: SPREAD_W] = best_spread_q;
		out_word[ROW_LO +: ROW_OUT_W]   = row_ext[ROW_OUT_W-1:0];
	end

	// Output register: holds a report until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_data_q <= out_word;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

// ===== src/tkst_ctrl.sv =====
// Sequencer of the tracker: accepts a row, steps the list unit through
// its readings one a cycle, then runs the spread update and, for an
// end-of-report row, the report. Depends on tkst_pkg.
`default_nettype none
module tkst_ctrl
	import tkst_pkg::*;
#(
	parameter int LANES = LANES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_fire,
	input  wire logic                       eor,
	input  wire logic                       out_free,
	output logic                            in_ready,
	output logic [$clog2(LANES)-1:0]        lane,
	output ctrl_t                           ctrl
);

	localparam int LANE_W = $clog2(LANES);

	tkst_state_t state_q, state_d;
	logic [LANE_W-1:0] lane_q;
	logic last_lane;

	assign last_lane = (lane_q == LANE_W'(LANES - 1));
	assign lane      = lane_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				if (last_lane) begin
					state_d = ST_SPREAD;
				end
			end
			ST_SPREAD: begin
				state_d = eor ? ST_REPORT : ST_IDLE;
			end
			ST_REPORT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs decoded from the state.
	always_comb begin
		ctrl     = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_INSERT: begin
				ctrl.ins_en = 1'b1;
				ctrl.first  = (lane_q == '0);
			end
			ST_SPREAD: begin
				ctrl.spread_en = 1'b1;
			end
			ST_REPORT: begin
				ctrl.out_load = out_free;
				ctrl.clear    = out_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	// State register and lane counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INSERT) begin
				lane_q <= last_lane ? '0 : lane_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/tkst_lists.sv =====
// Shared insertion unit: while ins_en is set, puts one reading a cycle into
// the sorted lists of the highest and lowest values, and tracks the minimum
// and maximum of the current row. Depends on tkst_pkg.
`default_nettype none
module tkst_lists
	import tkst_pkg::*;
#(
	parameter int TOP_K = TOP_K_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire ctrl_t ctrl,
	input  wire temp_t value,
	output temp_t      high_list [TOP_K],
	output temp_t      low_list [TOP_K],
	output temp_t      row_min,
	output temp_t      row_max
);

	temp_t high_q [TOP_K];
	temp_t low_q [TOP_K];
	temp_t high_d [TOP_K];
	temp_t low_d [TOP_K];
	temp_t row_min_q, row_max_q;
	logic [TOP_K-1:0] gt, lt;

	// Parallel insertion: every slot the value beats moves one place down,
	// and the value lands in the first such slot. The last slot falls out.
	always_comb begin
		for (int i = 0; i < TOP_K; i++) begin
			gt[i] = (value > high_q[i]);
			lt[i] = (value < low_q[i]);
		end
		for (int i = 0; i < TOP_K; i++) begin
			if (!gt[i]) begin
				high_d[i] = high_q[i];
			end else if (i == 0) begin
				high_d[i] = value;
			end else if (!gt[i-1]) begin
				high_d[i] = value;
			end else begin
				high_d[i] = high_q[i-1];
			end
			if (!lt[i]) begin
				low_d[i] = low_q[i];
			end else if (i == 0) begin
				low_d[i] = value;
			end else if (!lt[i-1]) begin
				low_d[i] = value;
			end else begin
				low_d[i] = low_q[i-1];
			end
		end
	end

	// List registers, cleared at reset and at the end of a report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOP_K; i++) begin
				high_q[i] <= temp_t'(TEMP_LOW);
				low_q[i]  <= temp_t'(TEMP_HIGH);
			end
		end else if (ctrl.clear) begin
			for (int i = 0; i < TOP_K; i++) begin
				high_q[i] <= temp_t'(TEMP_LOW);
				low_q[i]  <= temp_t'(TEMP_HIGH);
			end
		end else if (ctrl.ins_en) begin
			high_q <= high_d;
			low_q  <= low_d;
		end
	end

	// Row minimum and maximum; the first reading of a row starts them afresh.
	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (ctrl.first || value < row_min_q) begin
				row_min_q <= value;
			end
			if (ctrl.first || value > row_max_q) begin
				row_max_q <= value;
			end
		end
	end

	assign high_list = high_q;
	assign low_list  = low_q;
	assign row_min   = row_min_q;
	assign row_max   = row_max_q;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the top-K extreme and spread tracker.
// Drives rows over the input stream and checks every report against a predictor.
// Depends on tkst_pkg and top_k_extreme_and_spread_tracker.
`timescale 1ns / 1ps

module tb;
	import tkst_pkg::*;

	localparam int LANES    = LANES_DEF;
	localparam int TOP_K    = TOP_K_DEF;
	localparam int MAX_ROWS = MAX_ROWS_DEF;
	localparam int S_W      = ((LANES*TEMP_W+7)/8)*8;
	localparam int M_W      = ((2*TOP_K*TEMP_W+SPREAD_W+ROW_OUT_W+7)/8)*8;
	localparam int SPREAD_LSB = 2*TOP_K*TEMP_W;
	localparam int ROW_LSB    = SPREAD_LSB + SPREAD_W;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 30;
	localparam int NO_LIST [TOP_K] = '{0, 0, 0, 0, 0};

	// One report as the block sends it.
	typedef struct {
		temp_t                high [TOP_K];
		temp_t                low [TOP_K];
		logic [SPREAD_W-1:0]  spread;
		logic [ROW_OUT_W-1:0] row;
	} report_t;

	// One row of the directed table; the expected report is given only where typed is set.
	typedef struct {
		int reading [LANES];
		bit last;
		bit typed;
		int high [TOP_K];
		int low [TOP_K];
		int spread;
		int row;
	} stim_row_t;

	logic            clk;
	logic            arst_n;
	logic            s_axis_tvalid;
	logic            s_axis_tready;
	logic [S_W-1:0]  s_axis_tdata;
	logic            s_axis_tlast;
	logic            m_axis_tvalid;
	logic            m_axis_tready;
	logic [M_W-1:0]  m_axis_tdata;

	// Predictor state for the current report period.
	temp_t                hi_keep [TOP_K];
	temp_t                lo_keep [TOP_K];
	logic [SPREAD_W-1:0]  peak_spread;
	logic [ROW_OUT_W-1:0] peak_row;
	int                   row_idx;

	report_t reports_due [$];
	int      errors = 0;
	int      rows_sent = 0;
	int      reports_seen = 0;
	int      long_periods = 0;
	int      idle_pct = 15;
	int      hold_asks = 0;

	stim_row_t directed_rows [19] = '{
		'{'{-100, -100, -100, -100, -100, -100, -100, -100}, 1, 1,
			'{-100, -100, -100, -100, -100}, '{-100, -100, -100, -100, -100}, 0, 0},
		'{'{171, 171, 171, 171, 171, 171, 171, 171}, 1, 1,
			'{171, 171, 171, 171, 171}, '{171, 171, 171, 171, 171}, 0, 0},
		'{'{-100, 171, -100, 171, -100, 171, -100, 171}, 1, 1,
			'{171, 171, 171, 171, -100}, '{-100, -100, -100, -100, 171}, 271, 0},
		'{'{-256, -256, -256, -256, -256, -256, -256, -256}, 1, 1,
			'{-100, -100, -100, -100, -100}, '{-100, -100, -100, -100, -100}, 0, 0},
		'{'{255, 255, 255, 255, 255, 255, 255, 255}, 1, 1,
			'{171, 171, 171, 171, 171}, '{171, 171, 171, 171, 171}, 0, 0},
		'{'{-101, 172, -1, 0, 1, -2, 2, 100}, 1, 1,
			'{171, 100, 2, 1, 0}, '{-100, -2, -1, 0, 1}, 271, 0},
		'{'{0, 0, 0, 0, 0, 0, 0, 0}, 0, 0, NO_LIST, NO_LIST, 0, 0},
		'{'{7, 7, 7, 7, 7, 7, 7, 7}, 0, 0, NO_LIST, NO_LIST, 0, 0},
		'{'{-50, -50, -50, -50, -50, -50, -50, -50}, 1, 1,
			'{7, 7, 7, 7, 7}, '{-50, -50, -50, -50, -50}, 0, 0},
		'{'{0, 10, 5, 5, 5, 5, 5, 5}, 0, 0, NO_LIST, NO_LIST, 0, 0},
		'{'{-20, 10, 0, 0, 0, 0, 0, 0}, 0, 0, NO_LIST, NO_LIST, 0, 0},
		'{'{40, 70, 50, 50, 50, 50, 50, 50}, 0, 0, NO_LIST, NO_LIST, 0, 0},
		'{'{1, 2, 3, 4, 5, 6, 3, 2}, 1, 0, NO_LIST, NO_LIST, 0, 0},
		'{'{-256, 255, -129, 128, 85, -86, 170, -171}, 0, 0, NO_LIST, NO_LIST, 0, 0},
		'{'{-99, 170, -1, -1, 3, 3, 3, 3}, 0, 0, NO_LIST, NO_LIST, 0, 0},
		'{'{-100, -100, -100, -100, -100, -100, -100, -99}, 0, 0, NO_LIST, NO_LIST, 0, 0},
		'{'{171, 170, 169, 168, 167, 166, 165, 164}, 1, 0, NO_LIST, NO_LIST, 0, 0},
		'{'{3, 1, 4, 1, 5, 9, 2, 6}, 1, 0, NO_LIST, NO_LIST, 0, 0},
		'{'{-85, 86, -43, 42, -1, 1, 127, -128}, 1, 0, NO_LIST, NO_LIST, 0, 0}
	};

	top_k_extreme_and_spread_tracker uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Free-running clock, 20 ns period.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Returns the predictor to its cleared state.
	function automatic void clear_tracker();
		int i;
		for (i = 0; i < TOP_K; i++) begin
			hi_keep[i] = temp_t'(TEMP_LOW);
			lo_keep[i] = temp_t'(TEMP_HIGH);
		end
		peak_spread = '0;
		peak_row    = '0;
		row_idx     = 0;
	endfunction

	// Limits a raw reading to the legal temperature range.
	function automatic int limit_reading(int raw);
		int res;
		res = raw;
		if (raw < TEMP_LOW) begin
			res = TEMP_LOW;
		end else if (raw > TEMP_HIGH) begin
			res = TEMP_HIGH;
		end
		return res;
	endfunction

	// Folds one accepted row into the tracker; returns 1 with the report on an end-of-report row.
	function automatic bit absorb_row(input int reading [LANES], input bit last,
			output report_t rep);
		int    i, k, v, row_min, row_max;
		temp_t t;
		row_min = TEMP_HIGH;
		row_max = TEMP_LOW;
		for (i = 0; i < LANES; i++) begin
			v = limit_reading(int'(temp_t'(reading[i][TEMP_W-1:0])));
			// Highest list is kept descending, lowest list ascending.
			if (v > hi_keep[TOP_K-1]) begin
				hi_keep[TOP_K-1] = temp_t'(v);
				for (k = TOP_K - 1; k > 0 && hi_keep[k] > hi_keep[k-1]; k--) begin
					t = hi_keep[k];
					hi_keep[k] = hi_keep[k-1];
					hi_keep[k-1] = t;
				end
			end
			if (v < lo_keep[TOP_K-1]) begin
				lo_keep[TOP_K-1] = temp_t'(v);
				for (k = TOP_K - 1; k > 0 && lo_keep[k] < lo_keep[k-1]; k--) begin
					t = lo_keep[k];
					lo_keep[k] = lo_keep[k-1];
					lo_keep[k-1] = t;
				end
			end
			if (v < row_min) row_min = v;
			if (v > row_max) row_max = v;
		end
		// Only a strictly larger spread replaces the kept one, so the earliest row wins.
		if (row_max - row_min > int'(peak_spread)) begin
			peak_spread = SPREAD_W'(row_max - row_min);
			peak_row    = ROW_OUT_W'(row_idx);
		end
		row_idx = (row_idx + 1) % MAX_ROWS;
		rep.high   = hi_keep;
		rep.low    = lo_keep;
		rep.spread = peak_spread;
		rep.row    = peak_row;
		if (last) clear_tracker();
		return last;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endfunction

	// Mostly in-range readings, with some raw 9-bit patterns to reach the clamps.
	function automatic int random_reading();
		int res;
		if ($urandom_range(0, 9) == 0) begin
			res = int'($urandom_range(0, 511)) - 256;
		end else begin
			res = int'($urandom_range(0, TEMP_HIGH - TEMP_LOW)) + TEMP_LOW;
		end
		return res;
	endfunction

	function automatic int period_length();
		int res;
		if ($urandom_range(0, 11) == 0) begin
			res = $urandom_range(MAX_ROWS + 1, 2 * MAX_ROWS + 2);
		end else begin
			res = $urandom_range(1, 12);
		end
		return res;
	endfunction

	// Offers one row, waits for its transfer and runs the predictor on it.
	task automatic send_row(input int reading [LANES], input bit last,
			output bit made, output report_t rep);
		logic [S_W-1:0] word;
		int             i;
		word = '0;
		for (i = 0; i < LANES; i++) begin
			word[i*TEMP_W +: TEMP_W] = reading[i][TEMP_W-1:0];
		end
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		rows_sent++;
		made = absorb_row(reading, last, rep);
	endtask

	// Sends one report period of random rows, the last one flagged.
	task automatic send_period(input int len);
		int      reading [LANES];
		int      r, i;
		bit      dup, made;
		report_t rep;
		for (r = 0; r < len; r++) begin
			dup = ($urandom_range(0, 7) == 0);
			reading[0] = random_reading();
			for (i = 1; i < LANES; i++) begin
				reading[i] = dup ? reading[0] : random_reading();
			end
			send_row(reading, r == len - 1, made, rep);
			if (made) reports_due.push_back(rep);
		end
		if (len > MAX_ROWS) long_periods++;
	endtask

	// Drops valid and waits until every expected report has arrived.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (reports_due.size() != 0) @(posedge clk);
	endtask

	// Sender: directed table first, then random report periods.
	initial begin
		stim_row_t d;
		report_t   rep;
		bit        made;
		int        i;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		clear_tracker();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			d = directed_rows[k];
			send_row(d.reading, d.last, made, rep);
			if (made && d.typed) begin
				for (i = 0; i < TOP_K; i++) begin
					rep.high[i] = temp_t'(d.high[i]);
					rep.low[i]  = temp_t'(d.low[i]);
				end
				rep.spread = SPREAD_W'(d.spread);
				rep.row    = ROW_OUT_W'(d.row);
			end
			if (made) reports_due.push_back(rep);
		end

		// Random periods, one of them long enough to wrap the row index.
		send_period(MAX_ROWS + 6);
		while (rows_sent < 700) begin
			idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
			send_period(period_length());
		end
		wait_drained();

		// Receiver holds off while short periods keep coming, so the input stalls.
		idle_pct = 0;
		hold_asks++;
		repeat (20) send_period($urandom_range(1, 2));
		wait_drained();

		idle_pct = 15;
		while (rows_sent < 1100) begin
			idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
			send_period(period_length());
		end

		// Final stretch without idling on either side.
		idle_pct = 0;
		while (rows_sent < 1250) send_period($urandom_range(1, 12));

		s_axis_tvalid <= 1'b0;
		while (reports_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d rows and %0d reports, %0d periods past the row index wrap,",
			rows_sent, reports_seen, long_periods);
		$display("with clamped readings, spread ties, a long receiver hold-off and idle bursts.");
		if (errors == 0 && reports_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Receiver: random stall bursts, and one long hold-off when the sender asks for it.
	initial begin
		int hold_seen;
		hold_seen = 0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Compares each report transfer with the oldest expectation.
	always @(posedge clk) begin
		report_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			reports_seen++;
			if (reports_due.size() == 0) begin
				$error("report transfer with no expectation waiting");
				errors++;
			end else begin
				want = reports_due.pop_front();
				for (int i = 0; i < TOP_K; i++) begin
					check_field($sformatf("high_rank_%0d", i + 1), int'(want.high[i]),
						int'(temp_t'(m_axis_tdata[i*TEMP_W +: TEMP_W])));
					check_field($sformatf("low_rank_%0d", i + 1), int'(want.low[i]),
						int'(temp_t'(m_axis_tdata[(TOP_K+i)*TEMP_W +: TEMP_W])));
				end
				check_field("largest_spread", int'(want.spread),
					int'(m_axis_tdata[SPREAD_LSB +: SPREAD_W]));
				check_field("spread_row", int'(want.row),
					int'(m_axis_tdata[ROW_LSB +: ROW_OUT_W]));
			end
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
		$display("Some tests failed");
		$finish;
	end

endmodule
